/* rtl/tevq_pkg.sv */
// ----------------------------------------------------------------------------
// tevq_pkg
// Types and codes shared by the timed event queue modules.
// ----------------------------------------------------------------------------
package tevq_pkg;

    typedef enum logic [1:0] {
        FN_SCHEDULE = 2'd0,
        FN_CANCEL   = 2'd1,
        FN_TICK     = 2'd2,
        FN_NOP      = 2'd3
    } tevq_func_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_DUP       = 2'd2,
        STS_NOT_FOUND = 2'd3
    } tevq_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DECIDE,
        S_LAST
    } tevq_state_t;

    typedef struct packed {
        tevq_func_t  func;
        logic [15:0] event_id;
        logic [23:0] interval;
    } tevq_req_t;

    typedef struct packed {
        tevq_status_t status;
        logic         fired_valid;
        logic [15:0]  fired_id;
        logic         last;
    } tevq_rsp_t;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] deadline;
    } tevq_entry_t;

    // one entry presented to the scan unit
    typedef struct packed {
        logic        en;
        logic        used;
        tevq_entry_t entry;
    } tevq_probe_t;

    typedef struct packed {
        logic match;
        logic free;
        logic due;
    } tevq_scan_flags_t;

    localparam logic [4:0] CAP_RESET    = 5'd16;
    localparam logic [4:0] RESULT_LIMIT = 5'd16;

endpackage

/* rtl/tevq_slot_ram.sv */
// ----------------------------------------------------------------------------
// tevq_slot_ram
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tevq_slot_ram
    import tevq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  tevq_entry_t   wdata,
    input  logic [AW-1:0] raddr,
    output tevq_entry_t   rdata
);

    tevq_entry_t mem [DEPTH];
    tevq_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tevq_scan.sv */
// ----------------------------------------------------------------------------
// tevq_scan
// Scan unit: looks at one table entry a cycle while probe.en is set; keeps the first
// id match, the lowest free slot and the most overdue event seen since the last clear.
// ----------------------------------------------------------------------------
module tevq_scan
    import tevq_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  tevq_probe_t      probe,
    input  logic [IDX_W-1:0] probe_idx,
    input  logic [15:0]      key_id,
    input  logic [31:0]      now,
    output tevq_scan_flags_t flags,
    output logic [IDX_W-1:0] match_idx,
    output logic [IDX_W-1:0] free_idx,
    output logic [IDX_W-1:0] due_idx,
    output logic [15:0]      due_id
);

    tevq_scan_flags_t flags_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] due_idx_reg;
    logic [15:0]      due_id_reg;
    logic [31:0]      best_age_reg;

    logic [31:0] age;
    logic        hit_match;
    logic        hit_free;
    logic        hit_due;

    // entries come in ascending slot order, so strict compares keep the lower slot
    always_comb
    begin
        age       = now - probe.entry.deadline;
        hit_match = probe.en && probe.used && (probe.entry.id == key_id) && !flags_reg.match;
        hit_free  = probe.en && !probe.used && !flags_reg.free;
        hit_due   = probe.en && probe.used && !age[31]
                    && (!flags_reg.due || (age > best_age_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clear)
        begin
            flags_reg <= '0;
        end
        else
        begin
            if (hit_match)
            begin
                flags_reg.match <= 1'b1;
            end
            if (hit_free)
            begin
                flags_reg.free <= 1'b1;
            end
            if (hit_due)
            begin
                flags_reg.due <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_match)
        begin
            match_idx_reg <= probe_idx;
        end
        if (hit_free)
        begin
            free_idx_reg <= probe_idx;
        end
        if (hit_due)
        begin
            due_idx_reg  <= probe_idx;
            due_id_reg   <= probe.entry.id;
            best_age_reg <= age;
        end
    end

    assign flags     = flags_reg;
    assign match_idx = match_idx_reg;
    assign free_idx  = free_idx_reg;
    assign due_idx   = due_idx_reg;
    assign due_id    = due_id_reg;

endmodule

/* rtl/timed_event_queue_core.sv */
// ----------------------------------------------------------------------------
// timed_event_queue_core
// Table of pending timed events keyed by id: schedule, cancel and tick.
// ----------------------------------------------------------------------------
//  channel   signals                        transfer when
//  request   start, busy, req               start && !busy
//  response  rsp_strobe, rsp                rsp_strobe (one cycle, no stall)
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
//  Every command runs one sweep of the slot memory (S_SCAN, S_FLUSH), then
//  the S_DECIDE state, from which schedule and cancel give their result. A
//  tick that fires k < 16 events sweeps k + 1 times, one result per sweep
//  after the first; k = 16 sweeps 16 times and ends with the S_LAST state.
//  Reset clears the valid bits, count and time at once; no clearing pass.
//  busy stays high until the last result is registered.
// ----------------------------------------------------------------------------
module timed_event_queue_core
    import tevq_pkg::*;
#(
    parameter int MAX_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tevq_req_t req,
    output logic      rsp_strobe,
    output tevq_rsp_t rsp,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [4:0] cfg_data
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

    tevq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic                 rd_en_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    tevq_req_t            cmd_reg, cmd_next;
    logic [31:0]          now_reg, now_next;
    logic [4:0]           cap_reg;
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [4:0]           fired_reg, fired_next;
    logic                 held_valid_reg, held_valid_next;
    logic [15:0]          held_id_reg, held_id_next;
    logic                 rsp_strobe_reg, rsp_strobe_next;
    tevq_rsp_t            rsp_reg, rsp_next;

    logic             scan_clear;
    logic             ram_we;
    tevq_entry_t      ram_wdata;
    tevq_entry_t      ram_rdata;
    tevq_probe_t      probe;
    tevq_scan_flags_t flags;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] due_idx;
    logic [15:0]      due_id;
    logic             full;

    tevq_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign probe.en    = rd_en_reg;
    assign probe.used  = valid_reg[rd_idx_reg];
    assign probe.entry = ram_rdata;

    tevq_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .probe     (probe),
        .probe_idx (rd_idx_reg),
        .key_id    (cmd_reg.event_id),
        .now       (now_reg),
        .flags     (flags),
        .match_idx (match_idx),
        .free_idx  (free_idx),
        .due_idx   (due_idx),
        .due_id    (due_id)
    );

    // a count at MAX_SLOTS covers capacities above the table size
    assign full = (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                  || (count_reg == CNT_W'(MAX_SLOTS));

    assign ram_wdata.id       = cmd_reg.event_id;
    assign ram_wdata.deadline = now_reg + {8'd0, cmd_reg.interval};

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        fired_next      = fired_reg;
        held_valid_next = held_valid_reg;
        held_id_next    = held_id_reg;
        rsp_strobe_next = 1'b0;
        rsp_next        = rsp_reg;
        scan_clear      = 1'b0;
        ram_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = req;
                    addr_next       = '0;
                    scan_clear      = 1'b1;
                    fired_next      = '0;
                    held_valid_next = 1'b0;
                    state_next      = S_SCAN;
                    if (req.func == FN_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                end
            end

            S_SCAN:
            begin
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                rsp_next.status      = STS_OK;
                rsp_next.fired_valid = 1'b0;
                rsp_next.fired_id    = '0;
                rsp_next.last        = 1'b1;
                state_next           = S_IDLE;
                case (cmd_reg.func)
                    FN_SCHEDULE:
                    begin
                        rsp_strobe_next = 1'b1;
                        if (full)
                        begin
                            rsp_next.status = STS_FULL;
                        end
                        else if (flags.match)
                        begin
                            rsp_next.status = STS_DUP;
                        end
                        else
                        begin
                            ram_we               = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            count_next           = count_reg + CNT_W'(1);
                        end
                    end

                    FN_CANCEL:
                    begin
                        rsp_strobe_next = 1'b1;
                        if (flags.match)
                        begin
                            valid_next[match_idx] = 1'b0;
                            count_next            = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            rsp_next.status = STS_NOT_FOUND;
                        end
                    end

                    FN_TICK:
                    begin
                        if (flags.due)
                        begin
                            // the previous event is known not to be the final one
                            if (held_valid_reg)
                            begin
                                rsp_strobe_next      = 1'b1;
                                rsp_next.fired_valid = 1'b1;
                                rsp_next.fired_id    = held_id_reg;
                                rsp_next.last        = 1'b0;
                            end
                            held_valid_next     = 1'b1;
                            held_id_next        = due_id;
                            valid_next[due_idx] = 1'b0;
                            count_next          = count_reg - CNT_W'(1);
                            fired_next          = fired_reg + 5'd1;
                            if (fired_next == RESULT_LIMIT)
                            begin
                                state_next = S_LAST;
                            end
                            else
                            begin
                                scan_clear = 1'b1;
                                addr_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        else
                        begin
                            rsp_strobe_next = 1'b1;
                            if (held_valid_reg)
                            begin
                                rsp_next.fired_valid = 1'b1;
                                rsp_next.fired_id    = held_id_reg;
                            end
                        end
                    end

                    default:
                    begin
                        rsp_strobe_next = 1'b1;
                    end
                endcase
            end

            S_LAST:
            begin
                rsp_strobe_next      = 1'b1;
                rsp_next.status      = STS_OK;
                rsp_next.fired_valid = 1'b1;
                rsp_next.fired_id    = held_id_reg;
                rsp_next.last        = 1'b1;
                state_next           = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            addr_reg       <= '0;
            rd_en_reg      <= 1'b0;
            now_reg        <= '0;
            cap_reg        <= CAP_RESET;
            valid_reg      <= '0;
            count_reg      <= '0;
            fired_reg      <= '0;
            held_valid_reg <= 1'b0;
            rsp_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            rd_en_reg      <= (state_reg == S_SCAN);
            now_reg        <= now_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            fired_reg      <= fired_next;
            held_valid_reg <= held_valid_next;
            rsp_strobe_reg <= rsp_strobe_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= addr_reg;
        cmd_reg     <= cmd_next;
        held_id_reg <= held_id_next;
        rsp_reg     <= rsp_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign rsp_strobe = rsp_strobe_reg;
    assign rsp        = rsp_reg;

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for timed_event_queue_core. A short directed table
// covers the field extremes, every operation, full/duplicate/not-found, tie
// order and capacity saturation. Random phases follow, each with a new
// capacity and an idle rate for the sender (zero in the last two). Every
// result is compared with a behavioural copy of the event table.
// ----------------------------------------------------------------------------
module tb;
    import tevq_pkg::*;

    localparam int SLOTS       = 16;
    localparam int TAIL_CYCLES = 2 * (SLOTS + 3);
    localparam int QUIET_LIMIT = 3000;
    localparam int MAX_GAP     = 40;
    localparam int PHASES      = 6;

    typedef enum bit {ROW_CMD, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        tevq_req_t  req;
        logic [4:0] cap;
        bit         typed;
        tevq_rsp_t  rsp;
    } stim_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    tevq_req_t  req       = '0;
    logic       rsp_strobe;
    tevq_rsp_t  rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data  = '0;

    // behavioural copy of the event table
    logic [31:0] tbl_now;
    bit          tbl_used     [SLOTS];
    logic [15:0] tbl_id       [SLOTS];
    logic [31:0] tbl_deadline [SLOTS];
    logic [4:0]  tbl_cap;

    tevq_rsp_t event_outcome_q[$];
    stim_row_t stim_rows[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        idle_pct       = 0;

    int         phase_idle  [PHASES] = '{26, 26, 82, 82, 0, 0};
    logic [4:0] phase_cap   [PHASES] = '{5'd16, 5'd5, 5'd31, 5'd1, 5'd16, 5'd0};
    int         phase_items [PHASES] = '{80, 80, 80, 80, 80, 30};

    timed_event_queue_core #(
        .MAX_SLOTS (SLOTS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .rsp_strobe (rsp_strobe),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic tevq_rsp_t answer(tevq_status_t s);
        return '{status: s, fired_valid: 1'b0, fired_id: 16'h0, last: 1'b1};
    endfunction

    // Applies one command to the table copy and queues the results it causes.
    function automatic void advance_event_table(tevq_req_t r);
        int           cap_eff;
        int           count;
        int           found;
        int           best;
        int           n;
        logic [31:0]  age;
        logic [31:0]  best_age;
        tevq_rsp_t    fired;
        tevq_status_t st;

        found = -1;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_id[i] == r.event_id && found < 0)
                found = i;

        case (r.func)
            FN_SCHEDULE:
            begin
                cap_eff = (tbl_cap > SLOTS) ? SLOTS : int'(tbl_cap);
                count = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_used[i])
                        count++;
                if (count >= cap_eff)
                    st = STS_FULL;
                else if (found >= 0)
                    st = STS_DUP;
                else
                begin
                    st = STS_FULL;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!tbl_used[i] && st == STS_FULL)
                        begin
                            tbl_used[i]     = 1'b1;
                            tbl_id[i]       = r.event_id;
                            tbl_deadline[i] = tbl_now + {8'h0, r.interval};
                            st              = STS_OK;
                        end
                    end
                end
                event_outcome_q.push_back(answer(st));
            end
            FN_CANCEL:
            begin
                if (found >= 0)
                begin
                    tbl_used[found] = 1'b0;
                    event_outcome_q.push_back(answer(STS_OK));
                end
                else
                    event_outcome_q.push_back(answer(STS_NOT_FOUND));
            end
            FN_TICK:
            begin
                tbl_now = tbl_now + 32'd1;
                n = 0;
                best = 0;
                while (n < int'(RESULT_LIMIT) && best >= 0)
                begin
                    best = -1;
                    best_age = '0;
                    // oldest due first; strict compare keeps the lower slot on ties
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        age = tbl_now - tbl_deadline[i];
                        if (tbl_used[i] && !age[31] && (best < 0 || age > best_age))
                        begin
                            best = i;
                            best_age = age;
                        end
                    end
                    if (best >= 0)
                    begin
                        if (n > 0)
                            event_outcome_q.push_back(fired);
                        fired = '{status: STS_OK, fired_valid: 1'b1,
                                  fired_id: tbl_id[best], last: 1'b0};
                        tbl_used[best] = 1'b0;
                        n++;
                    end
                end
                if (n == 0)
                    event_outcome_q.push_back(answer(STS_OK));
                else
                begin
                    fired.last = 1'b1;
                    event_outcome_q.push_back(fired);
                end
            end
            default:
                event_outcome_q.push_back(answer(STS_OK));
        endcase
    endfunction

    function automatic tevq_req_t random_cmd();
        tevq_req_t   r;
        logic [15:0] live[$];
        int          pick;

        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i])
                live.push_back(tbl_id[i]);

        pick = $urandom_range(0, 99);
        r.func = (pick < 42) ? FN_SCHEDULE :
                 (pick < 58) ? FN_CANCEL :
                 (pick < 95) ? FN_TICK : FN_NOP;

        pick = $urandom_range(0, 99);
        if (live.size() > 0 && pick < 45)
            r.event_id = live[$urandom_range(0, live.size() - 1)];
        else if (pick < 75)
            r.event_id = 16'($urandom_range(0, 31));
        else
            r.event_id = 16'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 60)
            r.interval = 24'($urandom_range(0, 4));
        else if (pick < 94)
            r.interval = 24'($urandom_range(0, 60));
        else
            r.interval = 24'($urandom);
        return r;
    endfunction

    function automatic void put_cmd(tevq_func_t f, logic [15:0] id, logic [23:0] ival,
                                    bit typed, tevq_rsp_t want);
        stim_row_t row;

        row.kind  = ROW_CMD;
        row.req   = '{func: f, event_id: id, interval: ival};
        row.cap   = '0;
        row.typed = typed;
        row.rsp   = want;
        stim_rows.push_back(row);
    endfunction

    function automatic void put_cap(logic [4:0] v);
        stim_row_t row;

        row.kind  = ROW_CAP;
        row.req   = '0;
        row.cap   = v;
        row.typed = 1'b0;
        row.rsp   = '0;
        stim_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", field, got, want, $time);
        mismatch_count++;
    endtask

    // start stays high across back-to-back commands; it is lowered only for a gap, a capacity write and the end
    task automatic send_cmd(tevq_req_t r, bit typed, tevq_rsp_t want);
        int gap = 0;

        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        advance_event_table(r);
        if (typed)
        begin
            void'(event_outcome_q.pop_back());
            event_outcome_q.push_back(want);
        end
    endtask

    task automatic write_capacity(logic [4:0] v);
        start <= 1'b0;
        while (event_outcome_q.size() != 0 || busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tbl_cap = v;
    endtask

    always @(posedge clk)
    begin : rsp_check
        tevq_rsp_t want;

        if (rst_n && rsp_strobe === 1'b1)
        begin
            if (event_outcome_q.size() == 0)
                report_mismatch("result with nothing outstanding, id",
                                32'(rsp.fired_id), 32'd0);
            else
            begin
                want = event_outcome_q.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.fired_valid !== want.fired_valid)
                    report_mismatch("fired_valid", 32'(rsp.fired_valid),
                                    32'(want.fired_valid));
                if (rsp.fired_id !== want.fired_id)
                    report_mismatch("fired_id", 32'(rsp.fired_id), 32'(want.fired_id));
                if (rsp.last !== want.last)
                    report_mismatch("last", 32'(rsp.last), 32'(want.last));
            end
        end
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1 ||
            (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timed_event_queue_core verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [15:0] base;
        int          sent;
        int          n;

        tbl_now = '0;
        tbl_cap = CAP_RESET;
        foreach (tbl_used[i])
        begin
            tbl_used[i]     = 1'b0;
            tbl_id[i]       = '0;
            tbl_deadline[i] = '0;
        end

        put_cmd(FN_SCHEDULE, 16'h0000, 24'h000000, 1'b1, answer(STS_OK));
        put_cmd(FN_SCHEDULE, 16'h0000, 24'h000005, 1'b1, answer(STS_DUP));
        put_cmd(FN_CANCEL,   16'h0000, 24'h000000, 1'b1, answer(STS_OK));
        put_cmd(FN_CANCEL,   16'h0000, 24'h000000, 1'b1, answer(STS_NOT_FOUND));
        put_cmd(FN_NOP,      16'hFFFF, 24'hFFFFFF, 1'b1, answer(STS_OK));
        put_cmd(FN_TICK,     16'h0000, 24'h000000, 1'b1, answer(STS_OK));
        put_cmd(FN_SCHEDULE, 16'hFFFF, 24'hFFFFFF, 1'b1, answer(STS_OK));
        put_cmd(FN_SCHEDULE, 16'h1234, 24'h000000, 1'b1, answer(STS_OK));
        put_cmd(FN_SCHEDULE, 16'h00AA, 24'h000001, 1'b1, answer(STS_OK));
        put_cmd(FN_SCHEDULE, 16'h5555, 24'h000001, 1'b1, answer(STS_OK));
        // overdue one first, then the two equal deadlines by slot
        put_cmd(FN_TICK,     16'h0000, 24'h000000, 1'b0, '0);
        put_cmd(FN_CANCEL,   16'h00AA, 24'h000000, 1'b1, answer(STS_NOT_FOUND));
        put_cap(5'd1);
        put_cmd(FN_SCHEDULE, 16'h0001, 24'h000003, 1'b1, answer(STS_FULL));
        // full takes precedence over duplicate
        put_cmd(FN_SCHEDULE, 16'hFFFF, 24'h000003, 1'b1, answer(STS_FULL));
        put_cap(5'd0);
        put_cmd(FN_CANCEL,   16'hFFFF, 24'h000000, 1'b1, answer(STS_OK));
        put_cmd(FN_SCHEDULE, 16'h0002, 24'h000000, 1'b1, answer(STS_FULL));
        put_cmd(FN_TICK,     16'h0000, 24'h000000, 1'b1, answer(STS_OK));
        // capacity above the table size saturates
        put_cap(5'd31);
        put_cmd(FN_SCHEDULE, 16'hFFFF, 24'h000000, 1'b1, answer(STS_OK));
        put_cmd(FN_SCHEDULE, 16'h8000, 24'h000000, 1'b1, answer(STS_OK));
        put_cmd(FN_TICK,     16'h0000, 24'h000000, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 26;
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CAP)
                write_capacity(stim_rows[i].cap);
            else
                send_cmd(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            idle_pct = phase_idle[p];
            sent = 0;
            while (sent < phase_items[p])
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    // burst of near-simultaneous deadlines, then drain with ticks
                    n = $urandom_range(2, SLOTS);
                    base = 16'($urandom);
                    for (int k = 0; k < n; k++)
                        send_cmd('{func: FN_SCHEDULE, event_id: base + 16'(k),
                                   interval: 24'($urandom_range(0, 2))}, 1'b0, '0);
                    for (int k = 0; k < 4; k++)
                        send_cmd('{func: FN_TICK, event_id: 16'($urandom),
                                   interval: 24'($urandom)}, 1'b0, '0);
                    sent += n + 4;
                end
                else
                begin
                    send_cmd(random_cmd(), 1'b0, '0);
                    sent++;
                end
            end
        end

        start <= 1'b0;
        while (event_outcome_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("timed_event_queue_core verification clean");
        else
            $display("timed_event_queue_core verification failed");
        $finish;
    end

endmodule
